### rtl/core/obb_pkg.sv
// obb_pkg: shared types and constants for the opaque pixel bounding box.
// Holds register indexes, field widths and the structs passed between modules.
// No dependencies.
`default_nettype none

package obb_pkg;

	localparam int MAX_DIM_DEF = 4096;

	// wide enough for every signed rectangle sum and every counter value
	localparam int AW = 18;

	localparam int CFG_DW  = 14;
	localparam int CFG_IW  = 3;
	localparam int DIM_W   = 13;
	localparam int POS_W   = 14;
	localparam int ALPHA_W = 8;
	localparam int BOX_PW  = 12;
	localparam int BOX_SW  = 13;

	typedef enum logic [CFG_IW-1:0] {
		CFG_IMAGE_WIDTH  = 3'd0,
		CFG_IMAGE_HEIGHT = 3'd1,
		CFG_RECT_X       = 3'd2,
		CFG_RECT_Y       = 3'd3,
		CFG_RECT_WIDTH   = 3'd4,
		CFG_RECT_HEIGHT  = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic [DIM_W-1:0]        image_width;
		logic [DIM_W-1:0]        image_height;
		logic signed [POS_W-1:0] rect_x;
		logic signed [POS_W-1:0] rect_y;
		logic [DIM_W-1:0]        rect_width;
		logic [DIM_W-1:0]        rect_height;
	} cfg_t;

	// clamped rectangle and effective row/frame lengths
	typedef struct packed {
		logic signed [AW-1:0] x0;
		logic signed [AW-1:0] x1;
		logic signed [AW-1:0] y0;
		logic signed [AW-1:0] y1;
		logic [AW-1:0]        wc;
		logic [AW-1:0]        hc;
	} window_t;

	typedef struct packed {
		logic              found;
		logic [BOX_PW-1:0] box_x;
		logic [BOX_PW-1:0] box_y;
		logic [BOX_SW-1:0] box_width;
		logic [BOX_SW-1:0] box_height;
	} result_t;

endpackage

`default_nettype wire

### rtl/core/obb_window.sv
// obb_window: clamps the source rectangle to the image and derives row length.
// Purely combinational from the configuration registers. Uses obb_pkg.
`default_nettype none

module obb_window #(
	parameter int MAX_DIM = obb_pkg::MAX_DIM_DEF
) (
	input  obb_pkg::cfg_t    cfg,
	output obb_pkg::window_t win
);
	import obb_pkg::*;

	localparam logic [AW-1:0] MAX_DIM_W = AW'(MAX_DIM);

	logic [AW-1:0]        iw, ih, w_sat, h_sat;
	logic signed [AW-1:0] ws, hs, rx, ry, rx1, ry1;

	function automatic logic signed [AW-1:0] clamp(input logic signed [AW-1:0] v,
		input logic signed [AW-1:0] hi);
		logic signed [AW-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	always_comb begin
		iw    = AW'(cfg.image_width);
		ih    = AW'(cfg.image_height);
		w_sat = (iw > MAX_DIM_W) ? MAX_DIM_W : iw;
		h_sat = (ih > MAX_DIM_W) ? MAX_DIM_W : ih;
		ws    = signed'(w_sat);
		hs    = signed'(h_sat);
		rx    = AW'(cfg.rect_x);
		ry    = AW'(cfg.rect_y);
		rx1   = rx + signed'(AW'(cfg.rect_width));
		ry1   = ry + signed'(AW'(cfg.rect_height));
		win.x0 = clamp(rx, ws);
		win.x1 = clamp(rx1, ws);
		win.y0 = clamp(ry, hs);
		win.y1 = clamp(ry1, hs);
		win.wc = (w_sat == '0) ? AW'(1) : w_sat;
		win.hc = (h_sat == '0) ? AW'(1) : h_sat;
	end

endmodule

`default_nettype wire

### rtl/core/obb_track.sv
// obb_track: raster counters and min/max tracking of opaque pixels.
// Updates once per stepped beat and presents the finished box at frame end.
// Uses obb_pkg.
`default_nettype none

module obb_track #(
	parameter int MAX_DIM = obb_pkg::MAX_DIM_DEF,
	parameter int CW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [obb_pkg::ALPHA_W-1:0]    alpha,
	input  obb_pkg::window_t               win,
	output logic                           frame_end,
	output obb_pkg::result_t               result
);
	import obb_pkg::*;

	logic [CW-1:0] col_q, row_q, min_c_q, min_r_q, max_c_q, max_r_q;
	logic          seen_q;
	logic [CW-1:0] min_c_n, min_r_n, max_c_n, max_r_n;
	logic          seen_n, hit, col_last, row_last;
	logic signed [AW-1:0] cx, cy;
	logic [AW-1:0] min_c_w, min_r_w, wid_w, hgt_w;

	always_comb begin
		cx       = signed'(AW'(col_q));
		cy       = signed'(AW'(row_q));
		hit      = (alpha != '0) && (cx >= win.x0) && (cx < win.x1)
			&& (cy >= win.y0) && (cy < win.y1);
		col_last = (AW'(col_q) + AW'(1)) >= win.wc;
		row_last = (AW'(row_q) + AW'(1)) >= win.hc;
		frame_end = col_last && row_last;

		seen_n  = seen_q | hit;
		min_c_n = min_c_q;
		min_r_n = min_r_q;
		max_c_n = max_c_q;
		max_r_n = max_r_q;
		if (hit && !seen_q) begin
			min_c_n = col_q;
			max_c_n = col_q;
			min_r_n = row_q;
			max_r_n = row_q;
		end else if (hit) begin
			if (col_q < min_c_q) min_c_n = col_q;
			if (col_q > max_c_q) max_c_n = col_q;
			if (row_q < min_r_q) min_r_n = row_q;
			if (row_q > max_r_q) max_r_n = row_q;
		end

		min_c_w = AW'(min_c_n);
		min_r_w = AW'(min_r_n);
		wid_w   = AW'(max_c_n) - min_c_w + AW'(1);
		hgt_w   = AW'(max_r_n) - min_r_w + AW'(1);
		result.found      = seen_n;
		result.box_x      = seen_n ? min_c_w[BOX_PW-1:0] : '0;
		result.box_y      = seen_n ? min_r_w[BOX_PW-1:0] : '0;
		result.box_width  = seen_n ? wid_w[BOX_SW-1:0] : '0;
		result.box_height = seen_n ? hgt_w[BOX_SW-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			seen_q  <= 1'b0;
			min_c_q <= '0;
			min_r_q <= '0;
			max_c_q <= '0;
			max_r_q <= '0;
		end else if (step) begin
			if (frame_end) begin
				col_q   <= '0;
				row_q   <= '0;
				seen_q  <= 1'b0;
				min_c_q <= '0;
				min_r_q <= '0;
				max_c_q <= '0;
				max_r_q <= '0;
			end else begin
				if (col_last) begin
					col_q <= '0;
					row_q <= row_q + CW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
				seen_q  <= seen_n;
				min_c_q <= min_c_n;
				min_r_q <= min_r_n;
				max_c_q <= max_c_n;
				max_r_q <= max_r_n;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/opaque_pixel_bounding_box.sv
// Opaque pixel bounding box: one alpha byte per beat, one result per image.
// Throughput: one pixel per cycle; the input only stalls when a frame-end
// result meets a full, unread output register.
// The last pixel is registered at the input, then its result at the output.
// Reset: asynchronous, clears counters, box state and valids; registers reset
// to 64x64 image with a 64x64 rectangle at the origin.
`default_nettype none

module opaque_pixel_bounding_box #(
	parameter int MAX_DIM = obb_pkg::MAX_DIM_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [obb_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [obb_pkg::CFG_DW-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [obb_pkg::ALPHA_W-1:0]  alpha,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         found,
	output logic [obb_pkg::BOX_PW-1:0]   box_x,
	output logic [obb_pkg::BOX_PW-1:0]   box_y,
	output logic [obb_pkg::BOX_SW-1:0]   box_width,
	output logic [obb_pkg::BOX_SW-1:0]   box_height
);
	import obb_pkg::*;

	cfg_t                 cfg_q;
	window_t              win;
	result_t              res, res_q;
	logic [ALPHA_W-1:0]   alpha_s1;
	logic                 vld_s1, out_vld_q, frame_end, stall, adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= DIM_W'(64);
			cfg_q.image_height <= DIM_W'(64);
			cfg_q.rect_x       <= '0;
			cfg_q.rect_y       <= '0;
			cfg_q.rect_width   <= DIM_W'(64);
			cfg_q.rect_height  <= DIM_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data[DIM_W-1:0];
				CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[DIM_W-1:0];
				CFG_RECT_X:       cfg_q.rect_x       <= cfg_data;
				CFG_RECT_Y:       cfg_q.rect_y       <= cfg_data;
				CFG_RECT_WIDTH:   cfg_q.rect_width   <= cfg_data[DIM_W-1:0];
				CFG_RECT_HEIGHT:  cfg_q.rect_height  <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	obb_window #(.MAX_DIM(MAX_DIM)) u_window (
		.cfg (cfg_q),
		.win (win)
	);

	obb_track #(.MAX_DIM(MAX_DIM)) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.alpha     (alpha_s1),
		.win       (win),
		.frame_end (frame_end),
		.result    (res)
	);

	// only a frame-end beat needs the output register free
	assign stall    = vld_s1 && frame_end && out_vld_q && !out_ready;
	assign adv      = vld_s1 && !stall;
	assign in_ready = !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			alpha_s1 <= alpha;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv && frame_end) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && frame_end) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_vld_q;
	assign found      = res_q.found;
	assign box_x      = res_q.box_x;
	assign box_y      = res_q.box_y;
	assign box_width  = res_q.box_width;
	assign box_height = res_q.box_height;

endmodule

`default_nettype wire

### rtl/core/obb_checker.sv
// obb_checker: port-level checks on the bounding box result channel.
// Bound to opaque_pixel_bounding_box; uses obb_pkg for widths.
`default_nettype none

module obb_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        found,
	input logic [obb_pkg::BOX_PW-1:0]  box_x,
	input logic [obb_pkg::BOX_PW-1:0]  box_y,
	input logic [obb_pkg::BOX_SW-1:0]  box_width,
	input logic [obb_pkg::BOX_SW-1:0]  box_height
);
	import obb_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(box_x)
			&& $stable(box_y) && $stable(box_width) && $stable(box_height))
		else $error("result beat changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> box_x == '0 && box_y == '0 && box_width == '0
			&& box_height == '0)
		else $error("empty box carries nonzero fields");

	a_found_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> box_width != '0 && box_height != '0)
		else $error("found box has zero size");

	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid straight out of reset");

endmodule

bind opaque_pixel_bounding_box obb_checker u_obb_checker (.*);

`default_nettype wire

### verif/opaque_box_checker.sv
// opaque_box_checker: watches the register, alpha and result ports of the opaque
// pixel bounding box, predicts the box of each frame and compares every result beat.
// Depends on obb_pkg.
`default_nettype none

module opaque_box_checker #(
	parameter int MAX_DIM = obb_pkg::MAX_DIM_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [obb_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [obb_pkg::CFG_DW-1:0]   cfg_data,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [obb_pkg::ALPHA_W-1:0]  alpha,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic                         found,
	input  logic [obb_pkg::BOX_PW-1:0]   box_x,
	input  logic [obb_pkg::BOX_PW-1:0]   box_y,
	input  logic [obb_pkg::BOX_SW-1:0]   box_width,
	input  logic [obb_pkg::BOX_SW-1:0]   box_height,
	output int                           errors,
	output int                           pending
);
	import obb_pkg::*;

	localparam cfg_t REGS_AT_RESET = '{
		image_width: 64, image_height: 64, rect_x: 0, rect_y: 0,
		rect_width: 64, rect_height: 64
	};

	cfg_t regs = REGS_AT_RESET;
	int col_cnt = 0, row_cnt = 0;
	int min_col = 0, min_row = 0, max_col = 0, max_row = 0;
	bit seen_opaque = 1'b0;
	result_t expected_boxes[$];
	int fail_count = 0;
	int backlog = 0;

	assign errors = fail_count;
	assign pending = backlog;

	function automatic int clamp_dim(int v, int hi);
		return (v < 0) ? 0 : ((v > hi) ? hi : v);
	endfunction

	function automatic void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] d);
		case (idx)
			CFG_IMAGE_WIDTH:  regs.image_width = d[DIM_W-1:0];
			CFG_IMAGE_HEIGHT: regs.image_height = d[DIM_W-1:0];
			CFG_RECT_X:       regs.rect_x = d;
			CFG_RECT_Y:       regs.rect_y = d;
			CFG_RECT_WIDTH:   regs.rect_width = d[DIM_W-1:0];
			CFG_RECT_HEIGHT:  regs.rect_height = d[DIM_W-1:0];
			default: ;
		endcase
	endfunction

	// one pixel beat: grow the box, advance the raster position, close the frame
	function automatic void track_pixel(logic [ALPHA_W-1:0] a);
		int w, h, wc, hc, x0, x1, y0, y1;
		result_t box;
		w = (int'(regs.image_width) > MAX_DIM) ? MAX_DIM : int'(regs.image_width);
		h = (int'(regs.image_height) > MAX_DIM) ? MAX_DIM : int'(regs.image_height);
		wc = (w == 0) ? 1 : w;
		hc = (h == 0) ? 1 : h;
		x0 = clamp_dim($signed(regs.rect_x), w);
		x1 = clamp_dim($signed(regs.rect_x) + int'(regs.rect_width), w);
		y0 = clamp_dim($signed(regs.rect_y), h);
		y1 = clamp_dim($signed(regs.rect_y) + int'(regs.rect_height), h);
		if (a != '0 && col_cnt >= x0 && col_cnt < x1 && row_cnt >= y0 && row_cnt < y1) begin
			if (!seen_opaque) begin
				min_col = col_cnt;
				max_col = col_cnt;
				min_row = row_cnt;
				max_row = row_cnt;
				seen_opaque = 1'b1;
			end else begin
				if (col_cnt < min_col) min_col = col_cnt;
				if (col_cnt > max_col) max_col = col_cnt;
				if (row_cnt < min_row) min_row = row_cnt;
				if (row_cnt > max_row) max_row = row_cnt;
			end
		end
		if (col_cnt + 1 < wc) begin
			col_cnt++;
			return;
		end
		col_cnt = 0;
		if (row_cnt + 1 < hc) begin
			row_cnt++;
			return;
		end
		row_cnt = 0;
		box = '0;
		if (seen_opaque) begin
			box.found = 1'b1;
			box.box_x = min_col[BOX_PW-1:0];
			box.box_y = min_row[BOX_PW-1:0];
			box.box_width = BOX_SW'(max_col - min_col + 1);
			box.box_height = BOX_SW'(max_row - min_row + 1);
		end
		expected_boxes.push_back(box);
		seen_opaque = 1'b0;
		min_col = 0;
		min_row = 0;
		max_col = 0;
		max_row = 0;
	endfunction

	function automatic void compare_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			regs = REGS_AT_RESET;
			col_cnt = 0;
			row_cnt = 0;
			seen_opaque = 1'b0;
			min_col = 0;
			min_row = 0;
			max_col = 0;
			max_row = 0;
			expected_boxes.delete();
		end else begin
			if (cfg_we)
				write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				track_pixel(alpha);
			if (out_valid && out_ready) begin
				if (expected_boxes.size() == 0) begin
					$error("result beat with no box expected");
					fail_count++;
				end else begin
					want = expected_boxes.pop_front();
					compare_field("found", want.found, found);
					compare_field("box_x", want.box_x, box_x);
					compare_field("box_y", want.box_y, box_y);
					compare_field("box_width", want.box_width, box_width);
					compare_field("box_height", want.box_height, box_height);
				end
			end
		end
		backlog = expected_boxes.size();
	end

endmodule

`default_nettype wire

### verif/tb_opaque_pixel_bounding_box.sv
// tb_opaque_pixel_bounding_box: programs the registers, streams alpha beats and
// stalls the result port of the block; opaque_box_checker predicts and compares.
// Depends on obb_pkg, opaque_pixel_bounding_box and opaque_box_checker.
`default_nettype none

module tb_opaque_pixel_bounding_box;
	import obb_pkg::*;

	localparam logic [CFG_IW-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IW-1:0] CFG_SPARE_HI = 3'd7;
	localparam int IDLE_PCT = 34;
	localparam int RANDOM_PIXELS = 280;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [ALPHA_W-1:0] alpha = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic found;
	logic [BOX_PW-1:0] box_x, box_y;
	logic [BOX_SW-1:0] box_width, box_height;
	int box_errors;
	int boxes_pending;

	bit steady = 1'b0;
	logic [DIM_W-1:0] cur_w = 13'd64;
	logic [DIM_W-1:0] cur_h = 13'd64;
	int pixels_sent = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	opaque_pixel_bounding_box dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .alpha(alpha),
		.out_valid(out_valid), .out_ready(out_ready),
		.found(found), .box_x(box_x), .box_y(box_y),
		.box_width(box_width), .box_height(box_height)
	);

	opaque_box_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .alpha(alpha),
		.out_valid(out_valid), .out_ready(out_ready),
		.found(found), .box_x(box_x), .box_y(box_y),
		.box_width(box_width), .box_height(box_height),
		.errors(box_errors), .pending(boxes_pending)
	);

	always @(negedge clk)
		out_ready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);

	// leaves cfg_we high; the caller drops it after the last write
	task automatic write_reg(input logic [CFG_IW-1:0] idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DW-1:0];
		if (idx == CFG_IMAGE_WIDTH)
			cur_w = value[DIM_W-1:0];
		if (idx == CFG_IMAGE_HEIGHT)
			cur_h = value[DIM_W-1:0];
		@(negedge clk);
	endtask

	task automatic program_box(input int w, input int h, input int x, input int y,
			input int rw, input int rh);
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
		write_reg(CFG_RECT_X, x);
		write_reg(CFG_RECT_Y, y);
		write_reg(CFG_RECT_WIDTH, rw);
		write_reg(CFG_RECT_HEIGHT, rh);
		cfg_we <= 1'b0;
	endtask

	task automatic send_pixel(input logic [ALPHA_W-1:0] a);
		while (!steady && $urandom_range(99, 0) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		alpha <= a;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		pixels_sent++;
	endtask

	// sender holds off until every box is out and the pipeline has drained
	task automatic settle();
		in_valid <= 1'b0;
		wait (boxes_pending == 0);
		repeat (6) @(negedge clk);
	endtask

	function automatic int frame_len();
		int w, h;
		w = (cur_w > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(cur_w);
		h = (cur_h > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(cur_h);
		return ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
	endfunction

	function automatic logic [ALPHA_W-1:0] pick_alpha(int opaque_pct);
		if ($urandom_range(99, 0) < opaque_pct)
			return ALPHA_W'($urandom_range(255, 1));
		return '0;
	endfunction

	function automatic int random_reg_value(cfg_index_t r);
		case (r)
			CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT:
				return ($urandom_range(19, 0) == 0) ? 0 : $urandom_range(6, 1);
			CFG_RECT_X, CFG_RECT_Y:
				return ($urandom_range(4, 0) == 0) ? $urandom : $urandom_range(8, 0) - 3;
			default:
				return ($urandom_range(4, 0) == 0) ? $urandom : $urandom_range(8, 0);
		endcase
	endfunction

	initial begin
		#1_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int i, n, r, len, opaque_pct;
		bit wrote;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// unused indexes must be ignored; then a small frame with alpha extremes
		write_reg(CFG_SPARE_LO, 14'h3FFF);
		write_reg(CFG_SPARE_HI, 0);
		program_box(3, 2, 0, 0, 3, 2);
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_pixel(8'h00);
		send_pixel(8'h00);
		send_pixel(8'h00);
		send_pixel(8'h01);
		settle();

		// zero-width rectangle
		program_box(2, 1, 0, 0, 0, 5);
		send_pixel(8'hFF);
		send_pixel(8'hFF);
		settle();

		// rectangle wholly left of the image, most negative x
		program_box(2, 1, -8192, 0, 8191, 1);
		send_pixel(8'hFF);
		send_pixel(8'hFF);
		settle();

		// rectangle wholly right of the image, most positive x
		program_box(1, 1, 8191, 0, 1, 1);
		send_pixel(8'hFF);
		settle();

		// zero image size: every beat closes a frame
		program_box(0, 0, 0, 0, 4, 4);
		send_pixel(8'hFF);
		send_pixel(8'hFF);
		settle();

		// rectangle clipped on the left and at the bottom
		program_box(3, 3, -2, 1, 4, 8191);
		for (i = 0; i < 9; i++)
			send_pixel(8'h80);
		settle();

		// width shrunk mid-row: counter already past the new row end
		program_box(4, 1, 0, 0, 4, 1);
		send_pixel(8'h7F);
		send_pixel(8'h00);
		settle();
		write_reg(CFG_IMAGE_WIDTH, 2);
		cfg_we <= 1'b0;
		send_pixel(8'h10);
		settle();

		// long burst with no idling on either side, rectangle clipped at the top
		steady = 1'b1;
		program_box(40, 3, 2, -1, 30, 3);
		for (i = 0; i < frame_len(); i++)
			send_pixel(pick_alpha(5));
		settle();
		steady = 1'b0;

		n = pixels_sent + RANDOM_PIXELS;
		while (pixels_sent < n) begin
			wrote = 1'b0;
			for (r = CFG_IMAGE_WIDTH; r <= CFG_RECT_HEIGHT; r++) begin
				if ($urandom_range(9, 0) < 8) begin
					write_reg(r[CFG_IW-1:0], random_reg_value(cfg_index_t'(r)));
					wrote = 1'b1;
				end
			end
			if (wrote)
				cfg_we <= 1'b0;
			opaque_pct = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(90, 5);
			len = $urandom_range(3, 1) * frame_len();
			// now and then stop mid-frame, so the next settings land mid-image
			if ($urandom_range(9, 0) == 0)
				len += $urandom_range(4, 1);
			for (i = 0; i < len; i++)
				send_pixel(pick_alpha(opaque_pct));
			settle();
		end

		repeat (4) @(negedge clk);
		if (box_errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
